// File: design/periodic_task_timer_table_defines.svh
// Assertion shorthands for the checker file.
`ifndef PERIODIC_TASK_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_TASK_TIMER_TABLE_DEFINES_SVH

// Clocked assertion, masked while reset is held.
`define PTT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that also covers the reset cycles.
`define PTT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/ptt_pkg.sv
`timescale 1ns / 1ps
package ptt_pkg;

    localparam int PTT_SLOT_COUNT = 10;
    localparam int QDEPTH         = 2;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

    localparam logic [31:0] TICK_MS = 32'd10;

    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_HANDLER = 2'd1,
        ST_BAD_PERIOD = 2'd2,
        ST_FULL       = 2'd3
    } t_status;

    typedef struct packed {
        logic        is_tick;
        t_status     pre_status;
        logic [31:0] period;
        logic [31:0] tag;
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_REG,
        B_EVAL,
        B_DONE
    } t_back_state;

endpackage

// File: design/ptt_front.sv
`timescale 1ns / 1ps
module ptt_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [ptt_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic                               i_s_tuser,
    output logic                               o_q_valid,
    output ptt_pkg::t_cmd                      o_q_cmd,
    input  logic                               i_q_ready
);
    import ptt_pkg::*;

    logic    r_valid;
    t_cmd    r_cmd;
    t_cmd    n_cmd;
    logic    accept;
    logic    handler;
    logic [31:0] period;

    // Multiple of ten: even, and nibble sum divisible by five (16 = 1 mod 5).
    function automatic logic is_mult10(input logic [31:0] p);
        logic [6:0] s1;
        logic [4:0] s2;
        logic [4:0] s3;
        s1 = '0;
        for (int k = 0; k < 8; k++) begin
            s1 = s1 + 7'(p[4*k +: 4]);
        end
        s2 = 5'(s1[6:4]) + 5'(s1[3:0]);
        s3 = 5'(s2[4]) + 5'(s2[3:0]);
        return !p[0] && (s3 == 5'd0 || s3 == 5'd5 || s3 == 5'd10 || s3 == 5'd15);
    endfunction

    assign period  = i_s_tdata[31:0];
    assign handler = i_s_tdata[32];

    always_comb begin
        n_cmd.is_tick = (i_s_tuser == OP_TICK);
        n_cmd.period  = period;
        n_cmd.tag     = i_s_tdata[64:33];
        priority if (!handler) begin
            n_cmd.pre_status = ST_NO_HANDLER;
        end else if (period == 32'd0 || !is_mult10(period)) begin
            n_cmd.pre_status = ST_BAD_PERIOD;
        end else begin
            n_cmd.pre_status = ST_OK;
        end
    end

    assign o_s_tready = !r_valid || i_q_ready;
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_q_valid = r_valid;
    assign o_q_cmd   = r_cmd;

endmodule

// File: design/ptt_fifo.sv
`timescale 1ns / 1ps
module ptt_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ptt_pkg::t_cmd i_push_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output ptt_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import ptt_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_cmd             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// File: design/ptt_back.sv
`timescale 1ns / 1ps
module ptt_back #(
    parameter int SLOT_COUNT = ptt_pkg::PTT_SLOT_COUNT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  ptt_pkg::t_cmd                     i_q_cmd,
    output logic                              o_q_pop,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [ptt_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                              o_m_tuser,
    output logic                              o_m_tlast
);
    import ptt_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    function automatic logic [3:0] to_slot(input logic [CNT_W-1:0] v);
        logic [CNT_W+3:0] w;
        w = (CNT_W + 4)'(v);
        return w[3:0];
    endfunction

    logic [31:0] r_mem_period  [SLOT_COUNT];
    logic [31:0] r_mem_elapsed [SLOT_COUNT];
    logic [31:0] r_mem_tag     [SLOT_COUNT];
    logic [31:0] r_rd_period;
    logic [31:0] r_rd_elapsed;
    logic [31:0] r_rd_tag;

    t_back_state      r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [CNT_W-1:0] r_used, n_used;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_pend_valid, n_pend_valid;
    logic [3:0]       r_pend_slot, n_pend_slot;
    logic [31:0]      r_pend_tag, n_pend_tag;

    logic             r_out_valid;
    t_status          r_out_status;
    logic             r_out_fired;
    logic [3:0]       r_out_slot;
    logic [31:0]      r_out_tag;
    logic             r_out_last;

    logic             load_out;
    t_status          out_status;
    logic             out_fired;
    logic [3:0]       out_slot;
    logic [31:0]      out_tag;
    logic             out_last;

    logic             we_slot;
    logic             we_el;
    logic [IDX_W-1:0] el_addr;
    logic [31:0]      el_data;

    logic             out_free;
    logic [31:0]      sum;
    logic             fire;
    logic             at_end;
    logic             eval_go;
    logic             reg_ok;
    t_status          reg_status;

    assign out_free = !r_out_valid || i_m_tready;
    assign sum      = r_rd_elapsed + TICK_MS;
    assign fire     = (sum >= r_rd_period);
    assign at_end   = (CNT_W'(r_idx) == r_used - CNT_W'(1));
    // Hold the walk when a second firing finds the output still occupied.
    assign eval_go  = !(fire && r_pend_valid && !out_free);

    always_comb begin
        priority if (r_cmd.pre_status != ST_OK) begin
            reg_status = r_cmd.pre_status;
        end else if (r_used >= CNT_W'(SLOT_COUNT)) begin
            reg_status = ST_FULL;
        end else begin
            reg_status = ST_OK;
        end
    end
    assign reg_ok = (reg_status == ST_OK);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    if (!i_q_cmd.is_tick) begin
                        n_state = B_REG;
                    end else if (r_used == '0) begin
                        n_state = B_DONE;
                    end else begin
                        n_state = B_EVAL;
                    end
                end
            end
            B_REG: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            B_EVAL: begin
                if (eval_go && at_end) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Datapath control
    always_comb begin
        o_q_pop      = 1'b0;
        n_cmd        = r_cmd;
        n_used       = r_used;
        n_idx        = r_idx;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_pend_tag   = r_pend_tag;
        load_out     = 1'b0;
        out_status   = ST_OK;
        out_fired    = 1'b0;
        out_slot     = 4'd0;
        out_tag      = 32'd0;
        out_last     = 1'b1;
        we_slot      = 1'b0;
        we_el        = 1'b0;
        el_addr      = r_idx;
        el_data      = 32'd0;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_idx   = '0;
                end
            end
            B_REG: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    out_status = reg_status;
                    if (reg_ok) begin
                        out_slot = to_slot(r_used);
                        we_slot  = 1'b1;
                        we_el    = 1'b1;
                        el_addr  = r_used[IDX_W-1:0];
                        n_used   = r_used + 1'b1;
                    end
                end
            end
            B_EVAL: begin
                if (eval_go) begin
                    we_el   = 1'b1;
                    el_data = fire ? 32'd0 : sum;
                    if (fire) begin
                        // Flush the older firing; the newest waits to learn if it is last.
                        if (r_pend_valid) begin
                            load_out  = 1'b1;
                            out_fired = 1'b1;
                            out_slot  = r_pend_slot;
                            out_tag   = r_pend_tag;
                            out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_slot  = to_slot(CNT_W'(r_idx));
                        n_pend_tag   = r_rd_tag;
                    end
                    if (!at_end) begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            B_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (r_pend_valid) begin
                        out_fired    = 1'b1;
                        out_slot     = r_pend_slot;
                        out_tag      = r_pend_tag;
                        n_pend_valid = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_used       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_pend_valid <= n_pend_valid;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_idx       <= n_idx;
        r_pend_slot <= n_pend_slot;
        r_pend_tag  <= n_pend_tag;
        if (load_out) begin
            r_out_status <= out_status;
            r_out_fired  <= out_fired;
            r_out_slot   <= out_slot;
            r_out_tag    <= out_tag;
            r_out_last   <= out_last;
        end
    end

    // Slot memories: written at the used count or the walk index, one registered read at the next walk index.
    always_ff @(posedge i_clk) begin
        if (we_slot) begin
            r_mem_period[r_used[IDX_W-1:0]] <= r_cmd.period;
            r_mem_tag[r_used[IDX_W-1:0]]    <= r_cmd.tag;
        end
        if (we_el) begin
            r_mem_elapsed[el_addr] <= el_data;
        end
        r_rd_period  <= r_mem_period[n_idx];
        r_rd_elapsed <= r_mem_elapsed[n_idx];
        r_rd_tag     <= r_mem_tag[n_idx];
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_tag, r_out_slot, r_out_status};
    assign o_m_tuser  = r_out_fired;
    assign o_m_tlast  = r_out_last;

endmodule

// File: design/periodic_task_timer_table.sv
`timescale 1ns / 1ps
// Periodic timer table with SLOT_COUNT slots.
// Input stream: tuser is the operation (0 register, 1 tick of 10 ms); tdata
// carries period_ms, has_handler and tag. A registration is checked in the
// front stage (handler, period multiple of ten) and the table-full check is
// made when the back end takes it; it yields one result beat.
// A tick walks the used slots one per cycle through the slot memories and
// yields one beat per fired slot, in slot order, tlast on the final one, or
// a single empty beat when nothing fires.
// A registration result passes the front register, the command queue, the back
// end command register and the output register; the first beat of a tick also
// waits on the walk, since a firing is held until the next firing or the end
// of the walk shows whether it is last. The back end takes no new command until
// a registration or the whole walk of a tick has put out its last beat.
// A two-entry command queue sits between front and back, so input beats are
// taken, until it and the front register fill, while the back end works or
// the receiver stalls; when the receiver holds tready low the result beat holds
// and the walk pauses at a firing slot while another is held. Reset empties the
// queue and table (used count zero) and any pending result; slots keep contents.
module periodic_task_timer_table #(
    parameter int SLOT_COUNT = ptt_pkg::PTT_SLOT_COUNT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [31:0] period_ms, [32] has_handler, [64:33] tag, [71:65] zero
    input  logic [ptt_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // [0] operation
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [1:0] status, [5:2] slot, [37:6] fired_tag, [39:38] zero
    output logic [ptt_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // [0] fired
    output logic                             o_m_tuser,
    output logic                             o_m_tlast
);
    import ptt_pkg::*;

    logic f_valid;
    t_cmd f_cmd;
    logic q_ready;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    ptt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (f_valid),
        .o_q_cmd    (f_cmd),
        .i_q_ready  (q_ready)
    );

    ptt_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (f_valid),
        .i_push_cmd (f_cmd),
        .o_ready    (q_ready),
        .o_valid    (q_valid),
        .o_cmd      (q_cmd),
        .i_pop      (q_pop)
    );

    ptt_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// File: design/ptt_checker.sv
`timescale 1ns / 1ps
`include "periodic_task_timer_table_defines.svh"
module ptt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [ptt_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input logic                             o_m_tuser,
    input logic                             o_m_tlast
);
    import ptt_pkg::*;

    `PTT_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

    `PTT_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "stalled result beat changed")

    `PTT_ASSERT(a_plain_last, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser |-> o_m_tlast && o_m_tdata[37:6] == 32'd0, "non-fired beat not single and last")

    `PTT_ASSERT(a_fired_ok, i_clk, i_rst_n, o_m_tvalid && o_m_tuser |-> o_m_tdata[1:0] == 2'd0, "fired beat with nonzero status")

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// File: test/tb_periodic_task_timer_table.sv
`timescale 1ns / 1ps
module tb_periodic_task_timer_table;
    import ptt_pkg::*;

    typedef struct packed {
        t_status     status;
        logic        fired;
        logic [3:0]  slot;
        logic [31:0] tag;
        logic        last;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // [31:0] period_ms, [32] has_handler, [64:33] tag, [71:65] zero
    logic [IN_TDATA_W-1:0] i_s_tdata = '0;
    // [0] operation
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready;
    // [1:0] status, [5:2] slot, [37:6] fired_tag, [39:38] zero
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    // [0] fired
    logic        o_m_tuser;
    logic        o_m_tlast;

    // shadow copy of the timer table
    logic [31:0] tbl_period  [PTT_SLOT_COUNT];
    logic [31:0] tbl_elapsed [PTT_SLOT_COUNT];
    logic [31:0] tbl_tag     [PTT_SLOT_COUNT];
    int          tbl_used = 0;

    t_beat       awaited_beats[$];
    int          mismatches = 0;

    int unsigned tx_max_gap = 18;
    int unsigned rx_max_gap = 18;
    int unsigned rx_gap = 0;
    logic        rx_took = 1'b0;
    logic        rx_ready_r = 1'b0;
    int unsigned hold_req = 0;
    int unsigned hold_left = 0;
    logic        rx_hold = 1'b0;

    assign i_m_tready = rx_ready_r & ~rx_hold;

    periodic_task_timer_table dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Work out the beats one accepted item causes and advance the table copy.
    task automatic apply_to_table(input logic op, input logic [31:0] period,
                                  input logic handler, input logic [31:0] tag);
        t_beat plain;
        t_beat held;
        logic  have_held;
        plain = '{ST_OK, 1'b0, 4'd0, 32'd0, 1'b1};
        have_held = 1'b0;
        held = plain;
        if (op == OP_REGISTER) begin
            if (!handler) begin
                plain.status = ST_NO_HANDLER;
            end else if (period == 32'd0 || (period % TICK_MS) != 32'd0) begin
                plain.status = ST_BAD_PERIOD;
            end else if (tbl_used >= PTT_SLOT_COUNT) begin
                plain.status = ST_FULL;
            end else begin
                plain.slot = 4'(tbl_used);
                tbl_period[tbl_used] = period;
                tbl_elapsed[tbl_used] = 32'd0;
                tbl_tag[tbl_used] = tag;
                tbl_used++;
            end
            awaited_beats.push_back(plain);
        end else begin
            for (int i = 0; i < tbl_used; i++) begin
                tbl_elapsed[i] = tbl_elapsed[i] + TICK_MS;
                if (tbl_elapsed[i] >= tbl_period[i]) begin
                    tbl_elapsed[i] = 32'd0;
                    if (have_held)
                        awaited_beats.push_back(held);
                    held = '{ST_OK, 1'b1, 4'(i), tbl_tag[i], 1'b0};
                    have_held = 1'b1;
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                awaited_beats.push_back(held);
            end else begin
                awaited_beats.push_back(plain);
            end
        end
    endtask

    // Offer one item after a random gap; called and returning at a falling edge.
    task automatic send_item(input logic op, input logic [31:0] period,
                             input logic handler, input logic [31:0] tag);
        int unsigned gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {7'd0, tag, handler, period};
        do @(posedge i_clk); while (!o_s_tready);
        apply_to_table(op, period, handler, tag);
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, $urandom, 1'($urandom_range(0, 1)), $urandom);
    endtask

    // Drop valid and hold off until every awaited beat has arrived or the wait limit runs out.
    task automatic wait_drained();
        int k;
        i_s_tvalid <= 1'b0;
        k = 0;
        do begin
            @(negedge i_clk);
            k++;
        end while (awaited_beats.size() != 0 && k < 50000);
    endtask

    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            rx_took = 1'b1;
            got = '{t_status'(o_m_tdata[1:0]), o_m_tuser, o_m_tdata[5:2],
                    o_m_tdata[37:6], o_m_tlast};
            if (awaited_beats.size() == 0) begin
                $display("%0t: unexpected beat: status %0d fired %0b slot %0d tag %h last %0b",
                         $time, got.status, got.fired, got.slot, got.tag, got.last);
                mismatches++;
            end else begin
                want = awaited_beats.pop_front();
                if (got.status !== want.status || got.fired !== want.fired ||
                    got.slot !== want.slot || got.tag !== want.tag ||
                    got.last !== want.last) begin
                    $display("%0t: mismatch: expected status %0d fired %0b slot %0d tag %h last %0b",
                             $time, want.status, want.fired, want.slot, want.tag, want.last);
                    $display("%0t:           actual   status %0d fired %0b slot %0d tag %h last %0b",
                             $time, got.status, got.fired, got.slot, got.tag, got.last);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: wait a random number of cycles before each beat.
    always @(negedge i_clk) begin
        if (rx_took) begin
            rx_took = 1'b0;
            rx_gap = $urandom_range(0, rx_max_gap);
        end
        if (rx_gap != 0) begin
            rx_ready_r <= 1'b0;
            rx_gap--;
        end else begin
            rx_ready_r <= 1'b1;
        end
    end

    // Long receiver stall, counted here once a test asks for it.
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left <= hold_req - 1;
            hold_req  <= 0;
            rx_hold   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else begin
            rx_hold <= 1'b0;
        end
    end

    task automatic test_refusals();
        send_tick();
        send_item(OP_REGISTER, 32'd10, 1'b0, 32'hFFFF_FFFF);
        send_item(OP_REGISTER, 32'd0, 1'b0, 32'h0);
        send_item(OP_REGISTER, 32'd0, 1'b1, 32'h1234_5678);
        send_item(OP_REGISTER, 32'd5, 1'b1, 32'hFFFF_FFFF);
        send_item(OP_REGISTER, 32'hFFFF_FFFF, 1'b1, 32'hA5A5_A5A5);
        send_item(OP_REGISTER, 32'd15, 1'b1, 32'h0);
        send_tick();
    endtask

    task automatic test_extremes();
        send_item(OP_REGISTER, 32'hFFFF_FFFA, 1'b1, 32'hFFFF_FFFF);
        send_item(OP_REGISTER, 32'd10, 1'b1, 32'h0000_0000);
        send_item(OP_REGISTER, 32'd20, 1'b1, 32'h5A5A_5A5A);
        send_item(OP_REGISTER, 32'd10, 1'b1, 32'hFFFF_FFFF);
        repeat (4) send_tick();
    endtask

    task automatic test_random_mix();
        int unsigned r;
        logic [31:0] period;
        for (int n = 0; n < 130; n++) begin
            // stretches with and without idling on either side
            if (n == 45) begin
                tx_max_gap = 0;
                rx_max_gap <= 0;
            end else if (n == 75) begin
                tx_max_gap = 18;
                rx_max_gap <= 18;
            end else if (n == 105) begin
                tx_max_gap = 0;
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_tick();
            end else if (r < 84) begin
                period = 32'd10 * $urandom_range(1, 12);
                send_item(OP_REGISTER, period, 1'b1, $urandom);
            end else if (r < 88) begin
                period = 32'd10 * $urandom_range(1, 429496729);
                send_item(OP_REGISTER, period, 1'b1, $urandom);
            end else if (r < 94) begin
                send_item(OP_REGISTER, $urandom, 1'b0, $urandom);
            end else begin
                send_item(OP_REGISTER, $urandom, 1'b1, $urandom);
            end
        end
        tx_max_gap = 18;
    endtask

    task automatic test_backpressure();
        rx_max_gap <= 0;
        tx_max_gap = 0;
        hold_req <= 150;
        repeat (16) send_tick();
        wait_drained();
        rx_max_gap <= 18;
        tx_max_gap = 18;
        repeat (6) send_tick();
    endtask

    task automatic test_full_table();
        while (tbl_used < PTT_SLOT_COUNT)
            send_item(OP_REGISTER, 32'd10 * $urandom_range(1, 6), 1'b1, $urandom);
        send_item(OP_REGISTER, 32'd10, 1'b1, 32'hDEAD_0001);
        send_item(OP_REGISTER, 32'd7, 1'b0, 32'h0);
        send_item(OP_REGISTER, 32'hFFFF_FFFF, 1'b1, 32'h0);
        send_item(OP_REGISTER, 32'hFFFF_FFFA, 1'b1, 32'hFFFF_FFFF);
        repeat (8) send_tick();
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_refusals();
        test_extremes();
        wait_drained();
        test_random_mix();
        test_backpressure();
        test_full_table();
        wait_drained();
        repeat (30) @(negedge i_clk);
        if (mismatches == 0 && awaited_beats.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: periodic_task_timer_table.f
+incdir+design
design/ptt_pkg.sv
design/ptt_front.sv
design/ptt_fifo.sv
design/ptt_back.sv
design/periodic_task_timer_table.sv
design/ptt_checker.sv
test/tb_periodic_task_timer_table.sv
